FILE: hdl/chd_pkg.sv
package chd_pkg;

   localparam int FIELD_W          = 16;
   localparam int SAMPLE_WIDTH     = 16;
   localparam int ANGLE_ITERATIONS = 16;
   localparam int STEP_TABLE_LEN   = 24;
   localparam int FRAC_BITS        = 16;
   localparam int HEADING_W        = 9;

   localparam int NUM_ITER   = (ANGLE_ITERATIONS < STEP_TABLE_LEN) ? ANGLE_ITERATIONS
                                                                    : STEP_TABLE_LEN;
   localparam int ITER_IDX_W = $clog2(STEP_TABLE_LEN);

   // x/y carry the sample scaled by 2^FRAC_BITS plus headroom for the fold and cordic gain
   localparam int XY_PAD = 3;
   localparam int XY_W   = SAMPLE_WIDTH + FRAC_BITS + XY_PAD;
   // angle in degrees with FRAC_BITS fraction bits, range about -100 .. 280
   localparam int Z_W    = 27;
   localparam int DEG_RAW_W = Z_W - 1 - FRAC_BITS;

   localparam int HALF_TURN_DEG = 180;
   localparam int FULL_TURN_DEG = 360;

   localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(HALF_TURN_DEG) <<< FRAC_BITS;
   localparam logic signed [Z_W-1:0] FULL_TURN_Z = Z_W'(FULL_TURN_DEG) <<< FRAC_BITS;
   localparam logic signed [Z_W-1:0] ROUND_HALF  = Z_W'(1) <<< (FRAC_BITS - 1);

   // pipeline depth from accepted transaction to result strobe
   localparam int LATENCY = NUM_ITER + 2;

   typedef struct packed {
      logic                    zero;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
   } lane_data_type;

   typedef struct packed {
      logic          valid;
      lane_data_type data;
   } lane_type;

   // atan(2^-i) in degrees, scaled by 2^16, rounded to nearest
   function automatic logic signed [Z_W-1:0] step_angle(input logic [ITER_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         5'd0:    a = Z_W'(2949120);
         5'd1:    a = Z_W'(1740967);
         5'd2:    a = Z_W'(919879);
         5'd3:    a = Z_W'(466945);
         5'd4:    a = Z_W'(234379);
         5'd5:    a = Z_W'(117304);
         5'd6:    a = Z_W'(58666);
         5'd7:    a = Z_W'(29335);
         5'd8:    a = Z_W'(14668);
         5'd9:    a = Z_W'(7334);
         5'd10:   a = Z_W'(3667);
         5'd11:   a = Z_W'(1833);
         5'd12:   a = Z_W'(917);
         5'd13:   a = Z_W'(458);
         5'd14:   a = Z_W'(229);
         5'd15:   a = Z_W'(115);
         5'd16:   a = Z_W'(57);
         5'd17:   a = Z_W'(29);
         5'd18:   a = Z_W'(14);
         5'd19:   a = Z_W'(7);
         5'd20:   a = Z_W'(4);
         5'd21:   a = Z_W'(2);
         5'd22:   a = Z_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

FILE: hdl/compass_heading_degrees_core.sv
// Compass heading from one pair of signed magnetometer samples: atan2(mag_y, mag_x) in whole
// degrees 0..359, counterclockwise from X toward Y, rounded half up, with x = y = 0 giving 0.
// A transaction is taken on every cycle that start is high; busy stays low, so the block takes
// one sample pair per clock. Each result appears on rsp_heading_deg for exactly one cycle with
// rsp_valid high, in order; the depth is one input fold stage, one register stage per cordic
// iteration and one rounding stage. There is no back pressure: the receiver must take every
// result when it is strobed.
module compass_heading_degrees_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [chd_pkg::FIELD_W-1:0] req_mag_x,
   input  logic signed [chd_pkg::FIELD_W-1:0] req_mag_y,
   output logic                               rsp_valid,
   output logic [chd_pkg::HEADING_W-1:0]      rsp_heading_deg
);

   localparam int SW = chd_pkg::SAMPLE_WIDTH;
   localparam int FB = chd_pkg::FRAC_BITS;

   logic                          accept;
   logic signed [SW-1:0]          sx;
   logic signed [SW-1:0]          sy;
   logic signed [chd_pkg::XY_W-1:0] x_full;
   logic signed [chd_pkg::XY_W-1:0] y_full;

   logic                          prep_valid_ff;
   chd_pkg::lane_data_type        prep_data_ff;
   chd_pkg::lane_data_type        prep_data_in;

   chd_pkg::lane_type             lane [0:chd_pkg::NUM_ITER];

   logic signed [chd_pkg::Z_W-1:0]     z_fin;
   logic signed [chd_pkg::Z_W-1:0]     z_round;
   logic [chd_pkg::DEG_RAW_W-1:0]      deg_raw;
   logic [chd_pkg::DEG_RAW_W-1:0]      deg_wrap;

   logic                               rsp_valid_ff;
   logic [chd_pkg::HEADING_W-1:0]      rsp_heading_ff;
   logic [chd_pkg::HEADING_W-1:0]      rsp_heading_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // input fold: sign-extend samples, scale, turn left half-plane by a half turn
   always_comb begin
      sx = req_mag_x[SW-1:0];
      sy = req_mag_y[SW-1:0];
      x_full = {{chd_pkg::XY_PAD{sx[SW-1]}}, sx, {FB{1'b0}}};
      y_full = {{chd_pkg::XY_PAD{sy[SW-1]}}, sy, {FB{1'b0}}};
      prep_data_in.zero = (sx == '0) && (sy == '0);
      if (x_full[chd_pkg::XY_W-1]) begin
         prep_data_in.x = -x_full;
         prep_data_in.y = -y_full;
         prep_data_in.z = chd_pkg::HALF_TURN_Z;
      end else begin
         prep_data_in.x = x_full;
         prep_data_in.y = y_full;
         prep_data_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      prep_data_ff <= prep_data_in;
   end

   assign lane[0].valid = prep_valid_ff;
   assign lane[0].data  = prep_data_ff;

   for (genvar k = 0; k < chd_pkg::NUM_ITER; k++) begin : g_iter
      chd_cordic_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .step_index (chd_pkg::ITER_IDX_W'(k)),
         .lane_in    (lane[k]),
         .lane_out   (lane[k+1])
      );
   end

   // final rounding: wrap negative angle, round half up, fold 360 to 0, zero vector gives 0
   always_comb begin
      z_fin = lane[chd_pkg::NUM_ITER].data.z;
      if (z_fin[chd_pkg::Z_W-1]) begin
         z_round = z_fin + chd_pkg::FULL_TURN_Z + chd_pkg::ROUND_HALF;
      end else begin
         z_round = z_fin + chd_pkg::ROUND_HALF;
      end
      deg_raw = z_round[chd_pkg::Z_W-2:FB];
      if (deg_raw >= chd_pkg::DEG_RAW_W'(chd_pkg::FULL_TURN_DEG)) begin
         deg_wrap = deg_raw - chd_pkg::DEG_RAW_W'(chd_pkg::FULL_TURN_DEG);
      end else begin
         deg_wrap = deg_raw;
      end
      if (lane[chd_pkg::NUM_ITER].data.zero) begin
         rsp_heading_in = '0;
      end else begin
         rsp_heading_in = deg_wrap[chd_pkg::HEADING_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= lane[chd_pkg::NUM_ITER].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_heading_ff <= rsp_heading_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heading_deg = rsp_heading_ff;

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, chd_pkg::LATENCY))
      else $error("result strobe without a matching transaction");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_deg < chd_pkg::HEADING_W'(chd_pkg::FULL_TURN_DEG)))
      else $error("heading out of range");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mag_x[SW-1:0] == '0) && (req_mag_y[SW-1:0] == '0))
      |-> ##(chd_pkg::LATENCY) (rsp_valid && (rsp_heading_deg == '0)))
      else $error("zero vector did not give heading zero");

endmodule

FILE: hdl/chd_cordic_stage.sv
module chd_cordic_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [chd_pkg::ITER_IDX_W-1:0]      step_index,
   input  chd_pkg::lane_type                   lane_in,
   output chd_pkg::lane_type                   lane_out
);

   logic                       valid_ff;
   chd_pkg::lane_data_type     data_ff;
   chd_pkg::lane_data_type     data_in;

   logic signed [chd_pkg::XY_W-1:0] xs;
   logic signed [chd_pkg::XY_W-1:0] ys;
   logic signed [chd_pkg::Z_W-1:0]  step;

   always_comb begin
      xs   = lane_in.data.x >>> step_index;
      ys   = lane_in.data.y >>> step_index;
      step = chd_pkg::step_angle(step_index);
      data_in.zero = lane_in.data.zero;
      // rotate toward the positive x axis
      if (!lane_in.data.y[chd_pkg::XY_W-1]) begin
         data_in.x = lane_in.data.x + ys;
         data_in.y = lane_in.data.y - xs;
         data_in.z = lane_in.data.z + step;
      end else begin
         data_in.x = lane_in.data.x - ys;
         data_in.y = lane_in.data.y + xs;
         data_in.z = lane_in.data.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lane_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign lane_out.valid = valid_ff;
   assign lane_out.data  = data_ff;

endmodule

FILE: test/tb_compass_heading_degrees_core.sv
module tb_compass_heading_degrees_core;
   import chd_pkg::*;

   localparam int  STALL_LIMIT  = 2000;
   localparam int  TAIL_CYCLES  = LATENCY + 8;
   localparam int  RANDOM_PAIRS = 1650;
   localparam int  QUIET_TAIL   = 150;
   localparam real PI           = 3.14159265358979;

   typedef struct {
      logic [FIELD_W-1:0] mag_x;
      logic [FIELD_W-1:0] mag_y;
      bit                 drain_first;
   } sample_pair_type;

   typedef struct {
      logic [FIELD_W-1:0]   mag_x;
      logic [FIELD_W-1:0]   mag_y;
      logic [HEADING_W-1:0] heading;
   } heading_due_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 start           = 1'b0;
   logic [FIELD_W-1:0]   req_mag_x       = '0;
   logic [FIELD_W-1:0]   req_mag_y       = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [HEADING_W-1:0] rsp_heading_deg;

   // atan(2^-i) in degrees with 16 fraction bits
   longint atan_step_q16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };
   int corner_vals [0:5] = '{-32768, -32767, -1, 0, 1, 32767};

   sample_pair_type pending_samples [$];
   heading_due_type expected_headings [$];
   int  mismatch_count = 0;
   int  stall_cycles   = 0;
   int  gap_left       = 0;
   int  issued_count   = 0;
   bit  idle_enabled   = 1'b1;

   compass_heading_degrees_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mag_x       (req_mag_x),
      .req_mag_y       (req_mag_y),
      .rsp_valid       (rsp_valid),
      .rsp_heading_deg (rsp_heading_deg)
   );

   always #5 clock = ~clock;

   function automatic logic [HEADING_W-1:0] heading_of(input logic [FIELD_W-1:0] raw_x,
                                                       input logic [FIELD_W-1:0] raw_y);
      logic signed [SAMPLE_WIDTH-1:0] sx;
      logic signed [SAMPLE_WIDTH-1:0] sy;
      longint vx, vy, ang, shx, shy, deg;
      sx = raw_x[SAMPLE_WIDTH-1:0];
      sy = raw_y[SAMPLE_WIDTH-1:0];
      vx = sx;
      vy = sy;
      ang = 0;
      if (vx == 0 && vy == 0)
         return '0;
      vx = vx <<< FRAC_BITS;
      vy = vy <<< FRAC_BITS;
      // left half-plane: rotate by a half turn first
      if (vx < 0) begin
         vx  = -vx;
         vy  = -vy;
         ang = longint'(HALF_TURN_DEG) <<< FRAC_BITS;
      end
      for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
         shx = vx >>> i;
         shy = vy >>> i;
         if (vy >= 0) begin
            vx  = vx + shy;
            vy  = vy - shx;
            ang = ang + atan_step_q16[i];
         end else begin
            vx  = vx - shy;
            vy  = vy + shx;
            ang = ang - atan_step_q16[i];
         end
      end
      if (ang < 0)
         ang = ang + (longint'(FULL_TURN_DEG) <<< FRAC_BITS);
      deg = (ang + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      while (deg >= FULL_TURN_DEG)
         deg = deg - FULL_TURN_DEG;
      if (deg < 0)
         deg = 0;
      return deg[HEADING_W-1:0];
   endfunction

   task automatic add_sample(input int vx, input int vy, input bit drain_first);
      sample_pair_type item;
      item.mag_x       = vx[FIELD_W-1:0];
      item.mag_y       = vy[FIELD_W-1:0];
      item.drain_first = drain_first;
      pending_samples.push_back(item);
   endtask

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", what);
   endtask

   always @(posedge clock) begin : drive_samples
      sample_pair_type nxt;
      heading_due_type due;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            due.mag_x   = req_mag_x;
            due.mag_y   = req_mag_y;
            due.heading = heading_of(req_mag_x, req_mag_y);
            expected_headings.push_back(due);
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_samples.size() != 0 &&
                      !(pending_samples[0].drain_first && expected_headings.size() != 0)) begin
            nxt = pending_samples.pop_front();
            req_mag_x <= nxt.mag_x;
            req_mag_y <= nxt.mag_y;
            start     <= 1'b1;
            issued_count++;
            // switch between idling and back-to-back stretches
            if (issued_count % 128 == 0)
               idle_enabled = ($urandom_range(0, 2) != 0);
            if (idle_enabled && pending_samples.size() > QUIET_TAIL &&
                $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 19);
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_headings
      heading_due_type due;
      if (!reset && rsp_valid) begin
         if (expected_headings.size() == 0) begin
            flag_mismatch($sformatf("unexpected heading transaction: got %0d", rsp_heading_deg));
         end else begin
            due = expected_headings.pop_front();
            if (rsp_heading_deg !== due.heading)
               flag_mismatch($sformatf("heading for x=%0d y=%0d: expected %0d, got %0d",
                                       $signed(due.mag_x), $signed(due.mag_y),
                                       due.heading, rsp_heading_deg));
         end
      end
      if ((start && !busy) || rsp_valid)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL compass_heading_degrees_core");
         $finish;
      end
   end

   initial begin
      int  vx;
      int  vy;
      int  mag;
      int  pick;
      real ang;

      // axes, corners, zero vector, left half-plane, negative angle, wrap of 360 to 0
      add_sample(0, 0, 1'b0);
      add_sample(32767, 0, 1'b0);
      add_sample(-32768, 0, 1'b0);
      add_sample(0, 32767, 1'b0);
      add_sample(0, -32768, 1'b0);
      add_sample(32767, 32767, 1'b0);
      add_sample(-32768, -32768, 1'b0);
      add_sample(32767, -32768, 1'b0);
      add_sample(-32768, 32767, 1'b0);
      add_sample(1, 0, 1'b0);
      add_sample(-1, 0, 1'b0);
      add_sample(0, 1, 1'b0);
      add_sample(0, -1, 1'b0);
      add_sample(-1, -1, 1'b0);
      add_sample(-32768, 1, 1'b0);
      add_sample(-32768, -1, 1'b0);
      add_sample(32767, -1, 1'b0);
      add_sample(32767, 1, 1'b0);
      add_sample(100, -100, 1'b0);
      add_sample(-100, 100, 1'b0);
      add_sample(-21846, -21845, 1'b0);
      add_sample(1, -32768, 1'b0);

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            vx = $urandom;
            vy = $urandom;
         end else if (pick == 4) begin
            vx = int'($urandom_range(0, 6)) - 3;
            vy = int'($urandom_range(0, 6)) - 3;
         end else if (pick == 5) begin
            vx = $urandom;
            vy = 0;
            if ($urandom_range(0, 1) == 1) begin
               vy = vx;
               vx = 0;
            end
         end else if (pick == 6) begin
            vx = corner_vals[$urandom_range(0, 5)];
            vy = corner_vals[$urandom_range(0, 5)];
         end else if (pick <= 8) begin
            // rays at half-degree angles to stress the rounding tie
            mag = $urandom_range(1000, 32000);
            ang = ($itor($urandom_range(0, 359)) + 0.5) * PI / 180.0;
            vx  = $rtoi(mag * $cos(ang));
            vy  = $rtoi(mag * $sin(ang));
         end else begin
            mag = $urandom_range(1, 32767);
            vx  = ($urandom_range(0, 1) == 1) ? mag : -mag;
            vy  = ($urandom_range(0, 1) == 1) ? mag : -mag;
         end
         add_sample(vx, vy, i == 600 || i == 1200);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_samples.size() != 0 || start || expected_headings.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_headings.size() == 0)
         $display("PASS compass_heading_degrees_core");
      else
         $display("FAIL compass_heading_degrees_core");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/chd_pkg.sv
hdl/chd_cordic_stage.sv
hdl/compass_heading_degrees_core.sv
test/tb_compass_heading_degrees_core.sv
